/* rtl/core/prc_pkg.sv */
`default_nettype none
package prc_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int NUM_STAGES = 4;

    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_X_MAX = 2'd1;
    localparam logic [1:0] REG_Y_MIN = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    // stage order follows the register order
    localparam logic [1:0] STG_LEFT   = 2'd0;
    localparam logic [1:0] STG_RIGHT  = 2'd1;
    localparam logic [1:0] STG_BOTTOM = 2'd2;
    localparam logic [1:0] STG_TOP    = 2'd3;

endpackage
`default_nettype wire

/* rtl/core/prc_isect.sv */
`default_nettype none
module prc_isect #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [COORD_BITS-1:0] i_a_c,
    input  wire logic [COORD_BITS-1:0] i_b_c,
    input  wire logic [COORD_BITS-1:0] i_a_d,
    input  wire logic [COORD_BITS-1:0] i_b_d,
    input  wire logic [COORD_BITS-1:0] i_bound,
    output logic                       o_done,
    output logic [COORD_BITS-1:0]      o_result
);
    localparam int N  = COORD_BITS;
    localparam int CW = $clog2(2 * N + 1);
    localparam logic [CW-1:0] MUL_LAST = CW'(N - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(2 * N - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_isect_state;

    t_isect_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_hi, r_lo, r_mc, r_den, r_rem, r_ac;
    logic          r_neg;

    logic [N:0]   dv, du, db;
    logic [N-1:0] mag_dv, mag_du, mag_db;
    logic [N:0]   sum;
    logic [N:0]   t;
    logic         ge;
    logic [N:0]   t_sub;
    logic [N-1:0] qf;

    always_comb begin
        dv = {1'b0, i_b_c} - {1'b0, i_a_c};
        du = {1'b0, i_b_d} - {1'b0, i_a_d};
        db = {1'b0, i_bound} - {1'b0, i_a_d};
        mag_dv = dv[N] ? N'(-dv) : dv[N-1:0];
        mag_du = du[N] ? N'(-du) : du[N-1:0];
        mag_db = db[N] ? N'(-db) : db[N-1:0];
        sum = r_lo[0] ? ({1'b0, r_hi} + {1'b0, r_mc}) : {1'b0, r_hi};
        t = {r_rem, r_hi[N-1]};
        ge = t >= {1'b0, r_den};
        t_sub = t - {1'b0, r_den};
        // floor of a negative quotient: -(q+1) when inexact
        if (!r_neg) begin
            qf = r_lo;
        end else if (r_rem != '0) begin
            qf = ~r_lo;
        end else begin
            qf = N'(-r_lo);
        end
        o_result = r_ac + qf;
        o_done = (r_state == S_DONE);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_MUL;
            S_MUL:  if (r_cnt == MUL_LAST) n_state = S_DIV;
            S_DIV:  if (r_cnt == DIV_LAST) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL && r_cnt == MUL_LAST) begin
                r_cnt <= '0;
            end else if (r_state == S_MUL || r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_hi  <= '0;
                    r_lo  <= mag_dv;
                    r_mc  <= mag_db;
                    r_den <= mag_du;
                    r_rem <= '0;
                    r_ac  <= i_a_c;
                    r_neg <= dv[N] ^ db[N] ^ du[N];
                end
            end
            S_MUL: begin
                r_hi <= sum[N:1];
                r_lo <= {sum[0], r_lo[N-1:1]};
            end
            S_DIV: begin
                r_rem <= ge ? t_sub[N-1:0] : t[N-1:0];
                r_hi  <= {r_hi[N-2:0], r_lo[N-1]};
                r_lo  <= {r_lo[N-2:0], ge};
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/polygon_rect_clipper_unit.sv */
`default_nettype none
// each boundary crossing runs an edge state, a serial multiply, a restoring divide and a done
// state, plus sequencer states for each vertex
// one vertex at a time; the input is held stalled until the vertex has been handled,
// longer while the result output is stalled
// the closing vertex adds the closing edge of each of the four stages that has started
// reset: synchronous active low, clears control state and sets the clip window to full range
module polygon_rect_clipper_unit #(
    parameter int COORD_BITS = prc_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [COORD_BITS-1:0] i_vertex_x,
    input  wire logic [COORD_BITS-1:0] i_vertex_y,
    input  wire logic                  i_last_vertex,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [COORD_BITS-1:0]      o_out_x,
    output logic [COORD_BITS-1:0]      o_out_y,
    output logic                       o_out_valid_flag,
    output logic                       o_out_last,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [COORD_BITS-1:0] i_cfg_data
);
    import prc_pkg::*;

    localparam int N = COORD_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FEED  = 8'b0000_0010,
        S_EDGE  = 8'b0000_0100,
        S_CROSS = 8'b0000_1000,
        S_PICK  = 8'b0001_0000,
        S_EMIT  = 8'b0010_0000,
        S_CLOSE = 8'b0100_0000,
        S_FINAL = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic [N-1:0] r_clip [NUM_STAGES];
    logic [N-1:0] r_first_x [NUM_STAGES];
    logic [N-1:0] r_first_y [NUM_STAGES];
    logic [N-1:0] r_prev_x [NUM_STAGES];
    logic [N-1:0] r_prev_y [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_started;
    logic [N-1:0] r_pq_x [NUM_STAGES][2];
    logic [N-1:0] r_pq_y [NUM_STAGES][2];
    logic [1:0]   r_pcnt [NUM_STAGES];
    logic [1:0]   r_prd [NUM_STAGES];

    logic [N-1:0] r_px, r_py;
    logic [1:0]   r_lvl;
    logic [2:0]   r_cl;
    logic         r_close;
    logic         r_closing;
    logic         r_emitted;
    logic [N-1:0] r_held_x, r_held_y;

    logic         r_ov, r_ox_flag, r_olast;
    logic [N-1:0] r_ox, r_oy;

    logic         out_free;
    logic         load_out;
    logic [N-1:0] ax, ay, bx, by, bound;
    logic         ia, ib;
    logic         any_pend;
    logic [1:0]   pick;
    logic         x_stage;
    logic         isect_start, isect_done;
    logic [N-1:0] isect_res;
    logic [N-1:0] cx, cy;

    assign out_free    = !r_ov || !i_out_stall;
    assign load_out    = out_free && ((r_state == S_EMIT && r_emitted) || (r_state == S_FINAL));
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid      = r_ov;
    assign o_out_x          = r_ox;
    assign o_out_y          = r_oy;
    assign o_out_valid_flag = r_ox_flag;
    assign o_out_last       = r_olast;

    always_comb begin
        ax = r_prev_x[r_lvl];
        ay = r_prev_y[r_lvl];
        bx = r_closing ? r_first_x[r_lvl] : r_px;
        by = r_closing ? r_first_y[r_lvl] : r_py;
        bound = r_clip[r_lvl];
        unique case (r_lvl)
            STG_LEFT:   begin ia = ax >= bound; ib = bx >= bound; end
            STG_RIGHT:  begin ia = ax <= bound; ib = bx <= bound; end
            STG_BOTTOM: begin ia = ay >= bound; ib = by >= bound; end
            STG_TOP:    begin ia = ay <= bound; ib = by <= bound; end
            default:    begin ia = 1'b0; ib = 1'b0; end
        endcase
        x_stage = (r_lvl == STG_LEFT) || (r_lvl == STG_RIGHT);
        isect_start = (r_state == S_EDGE) && (ia != ib);
        cx = x_stage ? r_clip[r_lvl] : isect_res;
        cy = x_stage ? isect_res : r_clip[r_lvl];
    end

    // deepest stage with queued points goes first
    always_comb begin
        any_pend = 1'b0;
        pick = '0;
        for (int s = 0; s < NUM_STAGES; s++) begin
            if (r_prd[s] != r_pcnt[s]) begin
                any_pend = 1'b1;
                pick = 2'(s);
            end
        end
    end

    // edge ends are sampled by the intersection unit in the edge cycle
    prc_isect #(
        .COORD_BITS(COORD_BITS)
    ) u_isect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (isect_start),
        .i_a_c    (x_stage ? ay : ax),
        .i_b_c    (x_stage ? by : bx),
        .i_a_d    (x_stage ? ax : ay),
        .i_b_d    (x_stage ? bx : by),
        .i_bound  (bound),
        .o_done   (isect_done),
        .o_result (isect_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_clip[REG_X_MIN] <= '0;
            r_clip[REG_X_MAX] <= '1;
            r_clip[REG_Y_MIN] <= '0;
            r_clip[REG_Y_MAX] <= '1;
            r_started <= '0;
            r_emitted <= 1'b0;
            r_ov      <= 1'b0;
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_pcnt[s] <= '0;
                r_prd[s]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_clip[i_cfg_index] <= i_cfg_data;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_px      <= i_vertex_x;
                        r_py      <= i_vertex_y;
                        r_close   <= i_last_vertex;
                        r_lvl     <= STG_LEFT;
                        r_cl      <= '0;
                        r_closing <= 1'b0;
                        r_state   <= S_FEED;
                    end
                end
                S_FEED: begin
                    if (!r_started[r_lvl]) begin
                        r_started[r_lvl] <= 1'b1;
                        r_first_x[r_lvl] <= r_px;
                        r_first_y[r_lvl] <= r_py;
                        r_prev_x[r_lvl]  <= r_px;
                        r_prev_y[r_lvl]  <= r_py;
                        r_state <= S_PICK;
                    end else begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_prd[r_lvl] <= '0;
                    if (ia) begin
                        r_pq_x[r_lvl][0] <= ax;
                        r_pq_y[r_lvl][0] <= ay;
                        r_pcnt[r_lvl] <= 2'd1;
                    end else begin
                        r_pcnt[r_lvl] <= 2'd0;
                    end
                    if (r_closing) begin
                        r_started[r_lvl] <= 1'b0;
                    end else begin
                        r_prev_x[r_lvl] <= r_px;
                        r_prev_y[r_lvl] <= r_py;
                    end
                    r_state <= (ia != ib) ? S_CROSS : S_PICK;
                end
                S_CROSS: begin
                    if (isect_done) begin
                        r_pq_x[r_lvl][r_pcnt[r_lvl][0]] <= cx;
                        r_pq_y[r_lvl][r_pcnt[r_lvl][0]] <= cy;
                        r_pcnt[r_lvl] <= r_pcnt[r_lvl] + 2'd1;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (any_pend) begin
                        r_px <= r_pq_x[pick][r_prd[pick][0]];
                        r_py <= r_pq_y[pick][r_prd[pick][0]];
                        r_prd[pick] <= r_prd[pick] + 2'd1;
                        if (pick == STG_TOP) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_lvl     <= pick + 2'd1;
                            r_closing <= 1'b0;
                            r_state   <= S_FEED;
                        end
                    end else if (r_close) begin
                        r_state <= S_CLOSE;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    // the held vertex goes out only once a later one exists
                    if (!r_emitted || out_free) begin
                        if (r_emitted) begin
                            r_ox      <= r_held_x;
                            r_oy      <= r_held_y;
                            r_ox_flag <= 1'b1;
                            r_olast   <= 1'b0;
                        end
                        r_held_x  <= r_px;
                        r_held_y  <= r_py;
                        r_emitted <= 1'b1;
                        r_state   <= S_PICK;
                    end
                end
                S_CLOSE: begin
                    if (r_cl == 3'(NUM_STAGES)) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_cl      <= r_cl + 3'd1;
                        r_lvl     <= r_cl[1:0];
                        r_closing <= 1'b1;
                        if (r_started[r_cl[1:0]]) begin
                            r_state <= S_EDGE;
                        end
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        r_ox      <= r_emitted ? r_held_x : '0;
                        r_oy      <= r_emitted ? r_held_y : '0;
                        r_ox_flag <= r_emitted;
                        r_olast   <= 1'b1;
                        r_emitted <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_in_cross: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        isect_done |-> (r_state == S_CROSS))
        else $error("intersection result arrived outside a crossing wait");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && out_free) |=> (!r_emitted && r_ov && r_olast))
        else $error("polygon close did not flush the held vertex");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcnt[0] != 2'd3) && (r_pcnt[1] != 2'd3) && (r_pcnt[2] != 2'd3)
        && (r_pcnt[3] != 2'd3))
        else $error("stage queue overflow");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !any_pend)
        else $error("points left queued while idle");

endmodule
`default_nettype wire

/* bench/polygon_rect_clipper_checker.sv */
`timescale 1ns / 1ps
module polygon_rect_clipper_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [11:0] i_vertex_x,
    input  wire logic [11:0] i_vertex_y,
    input  wire logic        i_last_vertex,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [11:0] i_out_x,
    input  wire logic [11:0] i_out_y,
    input  wire logic        i_out_valid_flag,
    input  wire logic        i_out_last,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    import prc_pkg::*;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
    } t_point;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic        valid;
        logic        last;
    } t_clipped;

    logic [11:0] win_x_min, win_x_max, win_y_min, win_y_max;
    t_point      first_pt [NUM_STAGES];
    t_point      prev_pt [NUM_STAGES];
    bit          started [NUM_STAGES];
    bit          holding;
    t_point      held_pt;
    t_clipped    clipped_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit in_window(logic [1:0] stg, t_point p);
        case (stg)
            STG_LEFT:   return p.x >= win_x_min;
            STG_RIGHT:  return p.x <= win_x_max;
            STG_BOTTOM: return p.y >= win_y_min;
            default:    return p.y <= win_y_max;
        endcase
    endfunction

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        if (d == 0) return 0;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    // exact crossing with the stage boundary, rounded down
    function automatic t_point boundary_cross(logic [1:0] stg, t_point a, t_point b);
        longint bnd;
        t_point r;
        if (stg == STG_LEFT || stg == STG_RIGHT) begin
            bnd = (stg == STG_LEFT) ? longint'(win_x_min) : longint'(win_x_max);
            r.x = bnd[11:0];
            bnd = longint'(a.y) + floor_quot((longint'(b.y) - longint'(a.y))
                  * (bnd - longint'(a.x)), longint'(b.x) - longint'(a.x));
            r.y = bnd[11:0];
        end else begin
            bnd = (stg == STG_BOTTOM) ? longint'(win_y_min) : longint'(win_y_max);
            r.y = bnd[11:0];
            bnd = longint'(a.x) + floor_quot((longint'(b.x) - longint'(a.x))
                  * (bnd - longint'(a.y)), longint'(b.y) - longint'(a.y));
            r.x = bnd[11:0];
        end
        return r;
    endfunction

    function automatic void clip_edge(logic [1:0] stg, t_point a, t_point b,
                                      ref t_point dst[$]);
        bit ia, ib;
        ia = in_window(stg, a);
        ib = in_window(stg, b);
        if (ia) dst.push_back(a);
        if (ia != ib) dst.push_back(boundary_cross(stg, a, b));
    endfunction

    function automatic void clip_stage(logic [1:0] stg, t_point src[$], bit close,
                                       ref t_point dst[$]);
        foreach (src[i]) begin
            if (!started[stg]) begin
                first_pt[stg] = src[i];
                started[stg]  = 1'b1;
            end else begin
                clip_edge(stg, prev_pt[stg], src[i], dst);
            end
            prev_pt[stg] = src[i];
        end
        if (close && started[stg]) begin
            clip_edge(stg, prev_pt[stg], first_pt[stg], dst);
            started[stg] = 1'b0;
        end
    endfunction

    function automatic void clip_vertex(t_point v, bit close);
        t_point cur[$];
        t_point nxt[$];
        cur.push_back(v);
        for (int s = 0; s < NUM_STAGES; s++) begin
            nxt.delete();
            clip_stage(2'(s), cur, close, nxt);
            cur = nxt;
        end
        // one vertex is kept back so the real final one can carry the last flag
        foreach (cur[i]) begin
            if (holding) clipped_q.push_back('{held_pt.x, held_pt.y, 1'b1, 1'b0});
            held_pt = cur[i];
            holding = 1'b1;
        end
        if (close) begin
            if (holding) clipped_q.push_back('{held_pt.x, held_pt.y, 1'b1, 1'b1});
            else         clipped_q.push_back('{12'd0, 12'd0, 1'b0, 1'b1});
            holding = 1'b0;
            held_pt = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_clipped want;
        if (!i_rst_n) begin
            win_x_min = '0;
            win_x_max = '1;
            win_y_min = '0;
            win_y_max = '1;
            for (int s = 0; s < NUM_STAGES; s++) begin
                first_pt[s] = '0;
                prev_pt[s]  = '0;
                started[s]  = 1'b0;
            end
            holding = 1'b0;
            held_pt = '0;
            clipped_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_X_MIN: win_x_min = i_cfg_data;
                    REG_X_MAX: win_x_max = i_cfg_data;
                    REG_Y_MIN: win_y_min = i_cfg_data;
                    REG_Y_MAX: win_y_max = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                clip_vertex('{i_vertex_x, i_vertex_y}, i_last_vertex);
            if (i_out_valid && !i_out_stall) begin
                if (clipped_q.size() == 0) begin
                    $error("unexpected item: x=%0d y=%0d valid=%0b last=%0b",
                           i_out_x, i_out_y, i_out_valid_flag, i_out_last);
                    o_fail_count++;
                end else begin
                    want = clipped_q.pop_front();
                    if (i_out_x !== want.x) begin
                        $error("out_x: expected %0d, got %0d", want.x, i_out_x);
                        o_fail_count++;
                    end
                    if (i_out_y !== want.y) begin
                        $error("out_y: expected %0d, got %0d", want.y, i_out_y);
                        o_fail_count++;
                    end
                    if (i_out_valid_flag !== want.valid) begin
                        $error("out_valid: expected %0b, got %0b", want.valid,
                               i_out_valid_flag);
                        o_fail_count++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("out_last: expected %0b, got %0b", want.last, i_out_last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = clipped_q.size();
    end

endmodule

/* bench/tb_polygon_rect_clipper_unit.sv */
`timescale 1ns / 1ps
module tb_polygon_rect_clipper_unit;
    import prc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [11:0] i_vertex_x = '0;
    logic [11:0] i_vertex_y = '0;
    logic        i_last_vertex = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [11:0] o_out_x;
    logic [11:0] o_out_y;
    logic        o_out_valid_flag;
    logic        o_out_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [11:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int cycles = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    logic [11:0] lo_x, hi_x, lo_y, hi_y;

    polygon_rect_clipper_unit #(.COORD_BITS(12)) i_dut (.*);

    polygon_rect_clipper_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y), .i_last_vertex(i_last_vertex),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_out_x(o_out_x), .i_out_y(o_out_y),
        .i_out_valid_flag(o_out_valid_flag), .i_out_last(o_out_last),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_vertex(logic [11:0] x, logic [11:0] y, logic last);
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_vertex_x    <= x;
        i_vertex_y    <= y;
        i_last_vertex <= last;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // wait until the block is idle and every expected item has gone out
    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_in_stall) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_window(logic [11:0] x0, logic [11:0] x1,
                              logic [11:0] y0, logic [11:0] y1);
        end_burst();
        write_reg(REG_X_MIN, x0);
        write_reg(REG_X_MAX, x1);
        write_reg(REG_Y_MIN, y0);
        write_reg(REG_Y_MAX, y1);
        lo_x = x0; hi_x = x1; lo_y = y0; hi_y = y1;
    endtask

    function automatic logic [11:0] near(logic [11:0] a, logic [11:0] b);
        int lo, hi;
        lo = (a < b ? a : b) - 300;
        hi = (a < b ? b : a) + 300;
        if (lo < 0) lo = 0;
        if (hi > 4095) hi = 4095;
        return 12'($urandom_range(hi, lo));
    endfunction

    task automatic random_window();
        logic [11:0] a, b, c, d;
        case ($urandom_range(5))
            0: set_window(12'd0, 12'd4095, 12'd0, 12'd4095);
            1: set_window(12'd4095, 12'd4095, 12'd0, 12'd0);
            2: begin
                // inverted x range: min above max
                a = 12'($urandom_range(4095, 2048)); b = 12'($urandom_range(2047));
                set_window(a, b, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
            end
            default: begin
                a = 12'($urandom); b = 12'($urandom);
                c = 12'($urandom); d = 12'($urandom);
                set_window(a < b ? a : b, a < b ? b : a, c < d ? c : d, c < d ? d : c);
            end
        endcase
    endtask

    task automatic random_polygon(output int nv);
        logic wide;
        nv = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
        for (int i = 0; i < nv; i++) begin
            wide = ($urandom_range(1) == 0);
            send_vertex(wide ? 12'($urandom) : near(lo_x, hi_x),
                        wide ? 12'($urandom) : near(lo_y, hi_y), i == nv - 1);
        end
    endtask

    initial begin
        int nv, sent;
        lo_x = '0; hi_x = '1; lo_y = '0; hi_y = '1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full window after reset: corners and a lone vertex
        send_vertex(12'd0, 12'd0, 1'b0);
        send_vertex(12'd4095, 12'd0, 1'b0);
        send_vertex(12'd4095, 12'd4095, 1'b0);
        send_vertex(12'd0, 12'd4095, 1'b1);
        send_vertex(12'd5, 12'd7, 1'b1);

        set_window(12'd1000, 12'd3000, 12'd1000, 12'd3000);
        // triangle crossing every boundary
        send_vertex(12'd0, 12'd2000, 1'b0);
        send_vertex(12'd2000, 12'd0, 1'b0);
        send_vertex(12'd4095, 12'd4095, 1'b1);
        // lone vertex inside, then outside (fully clipped)
        send_vertex(12'd2000, 12'd2000, 1'b1);
        send_vertex(12'd0, 12'd0, 1'b1);
        // polygon wholly outside
        send_vertex(12'd0, 12'd0, 1'b0);
        send_vertex(12'd500, 12'd0, 1'b0);
        send_vertex(12'd500, 12'd500, 1'b1);
        // vertices on the boundary
        send_vertex(12'd1000, 12'd1000, 1'b0);
        send_vertex(12'd3000, 12'd3000, 1'b1);
        // diamond cutting three corners, with the fourth corner lying on an edge
        send_vertex(12'd2000, 12'd4000, 1'b0);
        send_vertex(12'd4000, 12'd2000, 1'b0);
        send_vertex(12'd2000, 12'd10, 1'b0);
        send_vertex(12'd10, 12'd2000, 1'b1);

        set_window(12'd3000, 12'd1000, 12'd2500, 12'd500);
        send_vertex(12'd0, 12'd0, 1'b0);
        send_vertex(12'd4095, 12'd4095, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            gap_pct   = (ph == 0) ? 21 : (ph == 1) ? 61 : 0;
            stall_pct = (ph == 0) ? 61 : (ph == 1) ? 21 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                random_window();
                sent = 0;
                while (sent < 40) begin
                    random_polygon(nv);
                    sent += nv;
                end
            end
        end

        end_burst();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/prc_pkg.sv
rtl/core/prc_isect.sv
rtl/core/polygon_rect_clipper_unit.sv
bench/polygon_rect_clipper_checker.sv
bench/tb_polygon_rect_clipper_unit.sv
